### sv/fcp_pkg.sv
package fcp_pkg;

   // Largest number of payload bytes that a P frame may carry.
   localparam int unsigned MAX_PAYLOAD = 64;
   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_PAYLOAD);

   // Field magnitudes and the widest value a multiply-by-ten accumulate can reach.
   localparam int unsigned MAG_W = 32;
   localparam int unsigned ACC_W = MAG_W + 4;
   localparam logic [ACC_W-1:0] POS_LIMIT = ACC_W'(36'h0_7FFF_FFFF);
   localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(36'h0_8000_0000);

   // Byte codes of the frame syntax.
   localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
   localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      CMD_M = 2'd0,
      CMD_A = 2'd1,
      CMD_D = 2'd2,
      CMD_P = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_DATA = 2'd1,
      PH_FIN  = 2'd2
   } phase_type;

   // Status of one payload field as seen by the frame control.
   typedef struct packed {
      logic neg;
      logic dig;
      logic ovf;
   } field_stat_type;

   // One result beat.
   typedef struct packed {
      cmd_type            command_code;
      logic               frame_accepted;
      logic               send_echo;
      logic               conversion_error;
      logic signed [31:0] value_first;
      logic signed [31:0] value_second;
      logic signed [31:0] value_third;
   } rsp_type;

endpackage

### sv/fcp_field.sv
module fcp_field (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       char_en,
   input  logic [7:0]                 rx_byte,
   output logic [fcp_pkg::MAG_W-1:0]  magnitude,
   output fcp_pkg::field_stat_type    stat
);
   import fcp_pkg::*;

   logic [MAG_W-1:0] acc_ff, acc_in;
   logic             start_ff, start_in;
   logic             neg_ff, neg_in;
   logic             dig_ff, dig_in;
   logic             end_ff, end_in;
   logic             is_dig;
   logic             is_blank;
   logic [ACC_W-1:0] next_acc;
   logic [ACC_W-1:0] limit;
   logic             too_big;

   // Multiply by ten as two shifts and an add, then add the digit.
   assign is_dig   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign is_blank = rx_byte inside {CH_SPACE, [CH_TAB:CH_CR]};
   assign next_acc = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                     + ACC_W'(rx_byte - CH_ZERO);
   assign limit    = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign too_big  = next_acc > limit;

   // String-to-integer rules, one byte at a time.
   always_comb begin
      acc_in   = acc_ff;
      start_in = start_ff;
      neg_in   = neg_ff;
      dig_in   = dig_ff;
      end_in   = end_ff;
      if (clear) begin
         acc_in   = '0;
         start_in = 1'b0;
         neg_in   = 1'b0;
         dig_in   = 1'b0;
         end_in   = 1'b0;
      end else if (char_en && !end_ff) begin
         if (is_dig) begin
            start_in = 1'b1;
            dig_in   = 1'b1;
            if (!too_big) begin
               acc_in = next_acc[MAG_W-1:0];
            end
         end else if (start_ff) begin
            end_in = 1'b1;
         end else if (!is_blank) begin
            start_in = 1'b1;
            if (rx_byte == CH_MINUS) begin
               neg_in = 1'b1;
            end else if (rx_byte != CH_PLUS) begin
               end_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         start_ff <= 1'b0;
         neg_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         end_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         start_ff <= start_in;
         neg_ff   <= neg_in;
         dig_ff   <= dig_in;
         end_ff   <= end_in;
      end
   end

   // Overflow is flagged for any digit that would land here; the caller gates it.
   assign magnitude = acc_ff;
   assign stat.neg  = neg_ff;
   assign stat.dig  = dig_ff;
   assign stat.ovf  = !end_ff && is_dig && too_big;

endmodule

### sv/framed_command_parser.sv
// Channel | Direction | Ports                                         | Beat
// req     | in        | req_valid, req_stall, req_rx_byte             | one received byte
// rsp     | out       | rsp_valid, rsp_stall, rsp_command_code ...    | one frame result
//
// Each byte is handled in the cycle it is accepted; the result of the byte that closes a frame
// is registered onto rsp. The block takes one byte per cycle while req_stall is low.
// Reset is synchronous and active high; it returns the parser to waiting for '<'.
// The result side has an output register plus a skid register, so req_stall
// rises only when both hold a beat, which happens after rsp_stall is held.
module framed_command_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_command_code,
   output logic                 rsp_frame_accepted,
   output logic                 rsp_send_echo,
   output logic                 rsp_conversion_error,
   output logic signed [31:0]   rsp_value_first,
   output logic signed [31:0]   rsp_value_second,
   output logic signed [31:0]   rsp_value_third
);
   import fcp_pkg::*;

   phase_type        phase_ff, phase_in;
   cmd_type          cmd_ff, cmd_in;
   logic             pmode_ff, pmode_in;
   logic [1:0]       idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             err_ff, err_in;

   logic             fire;
   logic             push;
   logic             pop;
   logic             field_clear;
   logic [2:0]       field_en;
   logic             any_ovf;
   logic             conv_err;
   rsp_type          res;
   logic [MAG_W-1:0] mag [3];
   field_stat_type   stat [3];
   logic [31:0]      val [3];

   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          skid_ff, skid_in;
   logic             skid_valid_ff, skid_valid_in;

   assign fire = req_valid && !req_stall;
   assign pop  = out_valid_ff && !rsp_stall;

   // One converter per payload field.
   for (genvar g = 0; g < 3; g++) begin : g_field
      fcp_field u_field (
         .clock     (clock),
         .reset     (reset),
         .clear     (field_clear),
         .char_en   (field_en[g]),
         .rx_byte   (req_rx_byte),
         .magnitude (mag[g]),
         .stat      (stat[g])
      );
      assign val[g] = stat[g].neg ? (32'd0 - mag[g]) : mag[g];
   end

   assign any_ovf  = |{field_en[2] & stat[2].ovf, field_en[1] & stat[1].ovf,
                       field_en[0] & stat[0].ovf};
   assign conv_err = err_ff || (idx_ff != 2'd2)
                     || !stat[0].dig || !stat[1].dig || !stat[2].dig;

   // Frame control: next state and the result beat of this byte.
   always_comb begin
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      pmode_in    = pmode_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      err_in      = err_ff;
      field_clear = 1'b0;
      field_en    = 3'b000;
      push        = 1'b0;
      res         = '0;
      res.command_code = cmd_ff;
      if (fire) begin
         case (phase_ff)
            PH_DATA: begin
               if (pmode_ff) begin
                  if (req_rx_byte == CH_CLOSE) begin
                     push                 = 1'b1;
                     res.command_code     = CMD_P;
                     res.frame_accepted   = 1'b1;
                     res.conversion_error = conv_err;
                     if (!conv_err) begin
                        res.value_first  = val[0];
                        res.value_second = val[1];
                        res.value_third  = val[2];
                     end
                     phase_in = PH_WAIT;
                  end else if (len_ff >= LEN_LIMIT) begin
                     err_in = 1'b1;
                  end else begin
                     len_in = len_ff + 1'b1;
                     if (req_rx_byte == CH_DOT && idx_ff < 2'd2) begin
                        idx_in = idx_ff + 1'b1;
                     end else begin
                        field_en[idx_ff] = 1'b1;
                        err_in = err_ff | any_ovf;
                     end
                  end
               end else begin
                  case (req_rx_byte)
                     CH_M: begin
                        cmd_in   = CMD_M;
                        phase_in = PH_FIN;
                     end
                     CH_A: begin
                        cmd_in   = CMD_A;
                        phase_in = PH_FIN;
                     end
                     CH_D: begin
                        cmd_in   = CMD_D;
                        phase_in = PH_FIN;
                     end
                     CH_P: begin
                        cmd_in   = CMD_P;
                        pmode_in = 1'b1;
                     end
                     default: begin
                        phase_in = PH_WAIT;
                     end
                  endcase
               end
            end
            PH_FIN: begin
               push               = 1'b1;
               res.frame_accepted = (req_rx_byte == CH_CLOSE);
               res.send_echo      = (req_rx_byte == CH_CLOSE) && (cmd_ff == CMD_D);
               phase_in           = PH_WAIT;
            end
            default: begin
               field_clear = 1'b1;
               cmd_in      = CMD_M;
               pmode_in    = 1'b0;
               idx_in      = 2'd0;
               len_in      = '0;
               err_in      = 1'b0;
               phase_in    = (req_rx_byte == CH_OPEN) ? PH_DATA : PH_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         cmd_ff   <= CMD_M;
         pmode_ff <= 1'b0;
         idx_ff   <= 2'd0;
         len_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         pmode_ff <= pmode_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         err_ff   <= err_in;
      end
   end

   // Output register with a skid register behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_command_code     = out_ff.command_code;
   assign rsp_frame_accepted   = out_ff.frame_accepted;
   assign rsp_send_echo        = out_ff.send_echo;
   assign rsp_conversion_error = out_ff.conversion_error;
   assign rsp_value_first      = out_ff.value_first;
   assign rsp_value_second     = out_ff.value_second;
   assign rsp_value_third      = out_ff.value_third;

endmodule

### tb/tb_framed_command_parser.sv
module tb_framed_command_parser;
   import fcp_pkg::*;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_command_code;
   logic                rsp_frame_accepted;
   logic                rsp_send_echo;
   logic                rsp_conversion_error;
   logic signed [31:0]  rsp_value_first;
   logic signed [31:0]  rsp_value_second;
   logic signed [31:0]  rsp_value_third;

   framed_command_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_command_code     (rsp_command_code),
      .rsp_frame_accepted   (rsp_frame_accepted),
      .rsp_send_echo        (rsp_send_echo),
      .rsp_conversion_error (rsp_conversion_error),
      .rsp_value_first      (rsp_value_first),
      .rsp_value_second     (rsp_value_second),
      .rsp_value_third      (rsp_value_third)
   );

   // Bytes waiting to be sent and frame results waiting to be seen.
   logic [7:0]  rx_stream [$];
   rsp_type     frame_results [$];

   // Shadow state of the frame parser.
   phase_type        sh_phase = PH_WAIT;
   cmd_type          sh_cmd = CMD_M;
   logic             sh_payload = 1'b0;
   logic [1:0]       sh_field = 2'd0;
   logic [ACC_W-1:0] sh_mag [3];
   logic [2:0]       sh_started = '0;
   logic [2:0]       sh_negative = '0;
   logic [2:0]       sh_digits = '0;
   logic [2:0]       sh_ended = '0;
   int unsigned      sh_length = 0;
   logic             sh_overflow = 1'b0;

   // Run bookkeeping.
   bit          byte_taken = 0;
   int unsigned bytes_taken = 0;
   int unsigned frames_checked = 0;
   int unsigned payload_frames = 0;
   int unsigned bad_payloads = 0;
   int unsigned mismatches = 0;
   int unsigned input_stalls = 0;

   // Idle control for both sides.
   int unsigned send_wait = 0;
   int unsigned send_calm = 0;
   int unsigned hold_left = 0;
   int unsigned recv_calm = 0;
   int unsigned squeeze_left = 0;
   bit          squeeze_done = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   task automatic clear_frame();
      sh_cmd = CMD_M;
      sh_payload = 1'b0;
      sh_field = 2'd0;
      sh_length = 0;
      sh_overflow = 1'b0;
      sh_started = '0;
      sh_negative = '0;
      sh_digits = '0;
      sh_ended = '0;
      for (int i = 0; i < 3; i++)
         sh_mag[i] = '0;
   endtask

   // One payload character applied to a field by string-to-integer rules.
   task automatic field_char(input int f, input logic [7:0] c);
      logic [ACC_W-1:0] next_mag;
      logic [ACC_W-1:0] limit;
      logic [3:0]       digit;
      digit = c[3:0];
      if (sh_ended[f])
         return;
      if (!sh_started[f]) begin
         if (is_blank(c))
            return;
         sh_started[f] = 1'b1;
         if (!is_digit(c)) begin
            if (c == CH_MINUS)
               sh_negative[f] = 1'b1;
            else if (c != CH_PLUS)
               sh_ended[f] = 1'b1;
            return;
         end
      end else if (!is_digit(c)) begin
         sh_ended[f] = 1'b1;
         return;
      end
      sh_digits[f] = 1'b1;
      limit = sh_negative[f] ? NEG_LIMIT : POS_LIMIT;
      next_mag = sh_mag[f] * 10 + digit;
      if (next_mag > limit)
         sh_overflow = 1'b1;
      else
         sh_mag[f] = next_mag;
   endtask

   // Advance the shadow parser by one byte and queue any frame result.
   task automatic parse_byte(input logic [7:0] c);
      rsp_type          r;
      logic             err;
      logic [31:0]      vals [3];
      r = '0;
      case (sh_phase)
         PH_DATA: begin
            if (sh_payload) begin
               if (c == CH_CLOSE) begin
                  err = sh_overflow || sh_field != 2'd2 || sh_digits != 3'b111;
                  for (int i = 0; i < 3; i++)
                     vals[i] = err ? 32'd0 :
                               sh_negative[i] ? -sh_mag[i][31:0] : sh_mag[i][31:0];
                  r.command_code = CMD_P;
                  r.frame_accepted = 1'b1;
                  r.conversion_error = err;
                  r.value_first = vals[0];
                  r.value_second = vals[1];
                  r.value_third = vals[2];
                  frame_results.push_back(r);
                  payload_frames++;
                  if (err)
                     bad_payloads++;
                  sh_phase = PH_WAIT;
               end else if (sh_length >= MAX_PAYLOAD) begin
                  sh_overflow = 1'b1;
               end else begin
                  sh_length++;
                  if (c == CH_DOT && sh_field < 2'd2)
                     sh_field++;
                  else
                     field_char(sh_field, c);
               end
            end else begin
               case (c)
                  CH_M: begin
                     sh_cmd = CMD_M;
                     sh_phase = PH_FIN;
                  end
                  CH_A: begin
                     sh_cmd = CMD_A;
                     sh_phase = PH_FIN;
                  end
                  CH_D: begin
                     sh_cmd = CMD_D;
                     sh_phase = PH_FIN;
                  end
                  CH_P: begin
                     sh_cmd = CMD_P;
                     sh_payload = 1'b1;
                  end
                  default: sh_phase = PH_WAIT;
               endcase
            end
         end
         PH_FIN: begin
            r.command_code = sh_cmd;
            r.frame_accepted = (c == CH_CLOSE);
            r.send_echo = (c == CH_CLOSE) && sh_cmd == CMD_D;
            frame_results.push_back(r);
            sh_phase = PH_WAIT;
         end
         default: begin
            clear_frame();
            sh_phase = (c == CH_OPEN) ? PH_DATA : PH_WAIT;
         end
      endcase
   endtask

   // Stimulus builders.
   task automatic put(input logic [7:0] b);
      rx_stream.push_back(b);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put(s[i]);
   endtask

   task automatic put_blank();
      int unsigned k;
      k = $urandom_range(0, 5);
      put(k == 5 ? CH_SPACE : CH_TAB + k[7:0]);
   endtask

   // Any byte that neither closes a frame nor separates fields.
   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CH_CLOSE || b == CH_DOT)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // One payload number with random blanks, sign, leading zeros and tail.
   task automatic put_number();
      int unsigned     kind;
      longint unsigned mag;
      string           digits;
      kind = $urandom_range(0, 19);
      mag = 0;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) put_blank();
      case ($urandom_range(0, 5))
         0: put(CH_MINUS);
         1: put(CH_PLUS);
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) put(CH_ZERO);
      case (kind)
         1: mag = 64'd2147483647;
         2: mag = 64'd2147483648;
         3: mag = 64'd2147483649;
         4: mag = {$urandom, $urandom} % 64'd100000000000;
         5, 6, 7, 8, 9, 10, 11: mag = 64'($urandom_range(0, 999));
         default: mag = 64'($urandom);
      endcase
      if (kind != 0) begin
         digits = $sformatf("%0d", mag);
         put_text(digits);
      end
      if ($urandom_range(0, 7) == 0)
         put(junk_byte());
   endtask

   task automatic put_payload_frame();
      int unsigned r;
      int unsigned fields;
      r = $urandom_range(0, 19);
      fields = (r == 0) ? 2 : (r == 1) ? 4 : (r == 2) ? 1 : 3;
      put(CH_OPEN);
      put(CH_P);
      // A rare long run of blanks can push the payload over its limit.
      if ($urandom_range(0, 24) == 0)
         repeat (MAX_PAYLOAD - 4 + $urandom_range(0, 12)) put_blank();
      for (int i = 0; i < fields; i++) begin
         if (i > 0)
            put(CH_DOT);
         put_number();
      end
      put(CH_CLOSE);
   endtask

   task automatic put_short_frame();
      int unsigned k;
      k = $urandom_range(0, 2);
      put(CH_OPEN);
      put(k == 0 ? CH_M : k == 1 ? CH_A : CH_D);
      if ($urandom_range(0, 6) == 0)
         put(8'($urandom_range(0, 255)));
      else
         put(CH_CLOSE);
   endtask

   task automatic put_bad_command();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == CH_M || b == CH_A || b == CH_D || b == CH_P)
         b = 8'($urandom_range(0, 255));
      put(CH_OPEN);
      put(b);
   endtask

   task automatic build_stimulus();
      int unsigned r;
      // Plain commands, echo request, wrong terminators and a bad command byte.
      put_text("<M><A><D><Dx<A<<Zq");
      // Payload extremes with a blank, a plus sign and a tab.
      put_text("<P-2147483648.+2147483647. ");
      put(CH_TAB);
      put_text("0>");
      // Positive overflow, missing dot, empty field.
      put_text("<P2147483648.1.1><P1.2><P.1.2>");
      // Extra dots, an open bracket and a zero byte inside the payload.
      put_text("<P7");
      put(8'h00);
      put_text(".-8x.9.4<>");
      while (rx_stream.size() < 1250) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            put_payload_frame();
         else if (r < 78)
            put_short_frame();
         else if (r < 86)
            put_bad_command();
         else
            repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
      end
   endtask

   // Byte driver: a new beat after each accepted one or after a gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (rx_stream.size() != 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_stream.pop_front();
            if (send_calm > 0) begin
               send_calm--;
               send_wait = 0;
            end else begin
               send_wait = idle_len();
               if ($urandom_range(0, 39) == 0)
                  send_calm = $urandom_range(20, 80);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off to fill the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (squeeze_left > 0) begin
         squeeze_left--;
         rsp_stall <= 1'b1;
      end else if (!squeeze_done && bytes_taken >= 400) begin
         squeeze_done = 1;
         squeeze_left = 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (recv_calm > 0) begin
            recv_calm--;
         end else begin
            hold_left = idle_len();
            if ($urandom_range(0, 39) == 0)
               recv_calm = $urandom_range(20, 80);
         end
      end
   end

   // Monitor: check result beats, then feed accepted bytes to the shadow parser.
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      bit      bad;
      byte_taken = 0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.command_code = cmd_type'(rsp_command_code);
            got.frame_accepted = rsp_frame_accepted;
            got.send_echo = rsp_send_echo;
            got.conversion_error = rsp_conversion_error;
            got.value_first = rsp_value_first;
            got.value_second = rsp_value_second;
            got.value_third = rsp_value_third;
            if (frame_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: cmd %0d acc %0b echo %0b err %0b",
                           got.command_code, got.frame_accepted, got.send_echo,
                           got.conversion_error);
            end else begin
               want = frame_results.pop_front();
               frames_checked++;
               bad = got.command_code !== want.command_code ||
                     got.frame_accepted !== want.frame_accepted ||
                     got.send_echo !== want.send_echo ||
                     got.conversion_error !== want.conversion_error ||
                     got.value_first !== want.value_first ||
                     got.value_second !== want.value_second ||
                     got.value_third !== want.value_third;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d mismatch, expected: cmd %0d acc %0b echo %0b",
                              frames_checked, want.command_code, want.frame_accepted,
                              want.send_echo);
                     $display("   err %0b values %0d %0d %0d",
                              want.conversion_error, want.value_first,
                              want.value_second, want.value_third);
                     $display("   actual: cmd %0d acc %0b echo %0b err %0b values %0d %0d %0d",
                              got.command_code, got.frame_accepted, got.send_echo,
                              got.conversion_error, got.value_first, got.value_second,
                              got.value_third);
                  end
               end
            end
         end
         if (req_valid && req_stall)
            input_stalls++;
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
            byte_taken = 1;
            bytes_taken++;
         end
      end
   end

   // Reset, stimulus, drain and verdict.
   initial begin
      clear_frame();
      build_stimulus();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (rx_stream.size() != 0 || req_valid)
         @(posedge clock);
      while (frame_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("summary: %0d bytes sent, %0d frame results checked, %0d of them payload frames",
               bytes_taken, frames_checked, payload_frames);
      $display("summary: %0d payloads flagged bad, input held off for %0d cycles",
               bad_payloads, input_stalls);
      if (mismatches == 0 && frame_results.size() == 0) begin
         $display("tb_framed_command_parser: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_framed_command_parser: FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5000000;
      $display("timeout with %0d results outstanding", frame_results.size());
      $display("tb_framed_command_parser: FAIL");
      $finish;
   end

endmodule

### sim.f
sv/fcp_pkg.sv
sv/fcp_field.sv
sv/framed_command_parser.sv
tb/tb_framed_command_parser.sv
